@@ hdl/sil_pkg.sv @@
// Shared types and constants for the sorted interval locator.
// Used by every module of the block; depends on nothing.
package sil_pkg;

	localparam int STORE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(STORE_DEPTH);
	localparam int NODE_W      = 10;
	localparam int COORD_W     = 32;
	localparam int LAST_W      = 11;
	localparam int CFG_IDX_W   = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int S_TDATA_W   = 48;
	localparam int M_TDATA_W   = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_CELL = 2'd1;

	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_LOCATE = 1'b1;

	localparam logic [1:0] KIND_WRITE  = 2'd0;
	localparam logic [1:0] KIND_QUERY  = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	typedef struct packed {
		logic [NODE_W-1:0] origin;
		logic [LAST_W-1:0] last_cell;
	} cfg_t;

	typedef struct packed {
		logic [1:0]                kind;
		logic [NODE_W-1:0]         node_index;
		logic signed [COORD_W-1:0] coordinate;
	} entry_t;

endpackage

@@ hdl/sil_front.sv @@
// Front end: holds the configuration registers, accepts input beats and
// classifies them into queue entries. Depends on sil_pkg.
module sil_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sil_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sil_pkg::LAST_W-1:0]          cfg_wdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [sil_pkg::S_TDATA_W-1:0]       s_tdata,
	input  logic                                s_tuser,
	input  logic                                q_full,
	output logic                                q_push,
	output sil_pkg::entry_t                     q_entry,
	output sil_pkg::cfg_t                       cfg
);

	sil_pkg::cfg_t               cfg_q;
	logic [sil_pkg::NODE_W-1:0]  node_index;
	logic [sil_pkg::NODE_W+1:0]  grid_end;
	logic                        drop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin    <= '0;
			cfg_q.last_cell <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				sil_pkg::REG_ORIGIN:    cfg_q.origin    <= cfg_wdata[sil_pkg::NODE_W-1:0];
				sil_pkg::REG_LAST_CELL: cfg_q.last_cell <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg        = cfg_q;
	assign node_index = s_tdata[sil_pkg::NODE_W-1:0];
	assign grid_end   = (sil_pkg::NODE_W+2)'(cfg_q.origin)
	                  + (sil_pkg::NODE_W+2)'(cfg_q.last_cell[sil_pkg::LAST_W-2:0])
	                  + (sil_pkg::NODE_W+2)'(1);

	// classify each beat into a queue entry, and drop writes beyond the store
	always_comb begin
		q_entry.node_index = node_index;
		q_entry.coordinate = s_tdata[sil_pkg::NODE_W +: sil_pkg::COORD_W];
		drop               = 1'b0;
		if (s_tuser == sil_pkg::MODE_WRITE) begin
			q_entry.kind = sil_pkg::KIND_WRITE;
			drop = (32'(node_index) >= 32'(sil_pkg::STORE_DEPTH));
		end else if (cfg_q.last_cell[sil_pkg::LAST_W-1]
		             || (32'(grid_end) >= 32'(sil_pkg::STORE_DEPTH))) begin
			q_entry.kind = sil_pkg::KIND_REJECT;
		end else begin
			q_entry.kind = sil_pkg::KIND_QUERY;
		end
	end

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && s_tready && !drop;

endmodule

@@ hdl/sil_queue.sv @@
// Short queue of classified entries between front and back end.
// Depends on sil_pkg.
module sil_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sil_pkg::entry_t  push_entry,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output sil_pkg::entry_t  head_entry
);

	sil_pkg::entry_t               slot_q [sil_pkg::QUEUE_DEPTH];
	logic [sil_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [sil_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [sil_pkg::QCNT_W-1:0]    count_q;
	logic                          do_push;
	logic                          do_pop;

	assign full       = (count_q == sil_pkg::QCNT_W'(sil_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + sil_pkg::QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + sil_pkg::QPTR_W'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + sil_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - sil_pkg::QCNT_W'(1);
				default: ;
			endcase
		end
	end

endmodule

@@ hdl/sil_back.sv @@
// Back end: node store, binary search sequencer and output register.
// Depends on sil_pkg.
module sil_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sil_pkg::cfg_t                    cfg,
	input  logic                             q_valid,
	input  sil_pkg::entry_t                  q_entry,
	output logic                             q_pop,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [sil_pkg::M_TDATA_W-1:0]    m_tdata
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LO   = 2'd1;
	localparam logic [1:0] ST_HI   = 2'd2;
	localparam logic [1:0] ST_STEP = 2'd3;

	localparam int IW = sil_pkg::IDX_W;
	localparam int NW = sil_pkg::NODE_W;

	logic signed [sil_pkg::COORD_W-1:0] store [sil_pkg::STORE_DEPTH];
	logic signed [sil_pkg::COORD_W-1:0] rd_data_q;
	logic signed [sil_pkg::COORD_W-1:0] key_q;

	logic [1:0]      state_q, state_n;
	logic [NW-1:0]   lo_q, hi_q, mid_q;
	logic [NW-1:0]   lo_n, hi_n, mid_n;
	logic [NW:0]     span;
	logic [NW-1:0]   top;
	logic            rd_en, wr_en;
	logic [IW-1:0]   rd_addr;
	logic            emit, emit_found;
	logic [NW-1:0]   emit_cell;
	logic            out_free;
	logic            m_valid_q, found_q;
	logic [NW-1:0]   cell_q;

	assign top      = cfg.last_cell[NW-1:0];
	assign out_free = !m_valid_q || m_tready;
	assign wr_en    = (state_q == ST_IDLE) && q_valid && (q_entry.kind == sil_pkg::KIND_WRITE);

	always_ff @(posedge clk) begin
		if (wr_en)
			store[IW'(q_entry.node_index)] <= q_entry.coordinate;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= store[rd_addr];
	end

	always_comb begin
		state_n    = state_q;
		q_pop      = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = IW'(cfg.origin);
		emit       = 1'b0;
		emit_found = 1'b0;
		emit_cell  = '0;
		lo_n       = lo_q;
		hi_n       = hi_q;
		if (state_q == ST_STEP) begin
			if (key_q >= rd_data_q) begin
				lo_n = mid_q;
			end else begin
				hi_n = mid_q - NW'(1);
			end
		end else if (state_q == ST_HI) begin
			lo_n = '0;
			hi_n = top;
		end
		span  = (NW+1)'(hi_n) - (NW+1)'(lo_n) + (NW+1)'(1);
		mid_n = lo_n + span[NW:1];

		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					case (q_entry.kind)
						sil_pkg::KIND_WRITE: q_pop = 1'b1;
						sil_pkg::KIND_QUERY: begin
							q_pop   = 1'b1;
							rd_en   = 1'b1;
							state_n = ST_LO;
						end
						default: begin
							if (out_free) begin
								q_pop = 1'b1;
								emit  = 1'b1;
							end
						end
					endcase
				end
			end
			ST_LO: begin
				if (key_q < rd_data_q) begin
					if (out_free) begin
						emit    = 1'b1;
						state_n = ST_IDLE;
					end
				end else begin
					rd_en   = 1'b1;
					rd_addr = IW'(cfg.origin) + IW'(top) + IW'(1);
					state_n = ST_HI;
				end
			end
			default: begin
				if (state_q == ST_HI && key_q >= rd_data_q) begin
					if (out_free) begin
						emit    = 1'b1;
						state_n = ST_IDLE;
					end
				end else if (lo_n < hi_n) begin
					rd_en   = 1'b1;
					rd_addr = IW'(cfg.origin) + IW'(mid_n);
					state_n = ST_STEP;
				end else if (out_free) begin
					emit       = 1'b1;
					emit_found = 1'b1;
					emit_cell  = lo_n;
					state_n    = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_pop)
			key_q <= q_entry.coordinate;
		if (rd_en) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= mid_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (emit)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			found_q <= emit_found;
			cell_q  <= emit_cell;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(sil_pkg::M_TDATA_W-NW-1)'(0), cell_q, found_q};

endmodule

@@ hdl/sorted_interval_locator.sv @@
// Sorted interval locator: node store written by load beats, binary search
// on query beats. The single read port of the node store serves every step of a
// search, so a new query starts only once the last one has emitted its result;
// loads go one per cycle while no query is in progress. Reset clears control state,
// origin to 0 and last_cell to -1; store contents are undefined until written.
module sorted_interval_locator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sil_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sil_pkg::LAST_W-1:0]        cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [sil_pkg::S_TDATA_W-1:0]     s_tdata,   // node_index, coordinate, zero pad
	input  logic                              s_tuser,   // mode
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sil_pkg::M_TDATA_W-1:0]     m_tdata    // found, cell_index, zero pad
);

	sil_pkg::cfg_t   cfg;
	sil_pkg::entry_t push_entry;
	sil_pkg::entry_t head_entry;
	logic            q_full, q_push, q_pop, q_valid;

	sil_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (push_entry),
		.cfg       (cfg)
	);

	sil_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_entry (head_entry)
	);

	sil_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_valid  (q_valid),
		.q_entry  (head_entry),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

@@ hdl/sil_checker.sv @@
// Port-level checks for the sorted interval locator, bound to the top level.
// Depends on sil_pkg.
module sil_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sil_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sil_pkg::LAST_W-1:0]        cfg_wdata,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [sil_pkg::S_TDATA_W-1:0]     s_tdata,
	input  logic                              s_tuser,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [sil_pkg::M_TDATA_W-1:0]     m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[10:1] == 10'd0)
		else $error("cell index not zero on a miss");

	a_cell_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[10:1] != 10'h3FF)
		else $error("cell index beyond the highest cell");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:11] == 5'd0)
		else $error("result pad bits not zero");

endmodule

bind sorted_interval_locator sil_checker u_sil_checker (.*);

@@ tb/sorted_interval_locator_tb.sv @@
`timescale 1ns / 100ps
// Testbench for sorted_interval_locator: streams node loads and interval queries,
// predicts each query result from its own node store and grid registers, and checks
// every result beat in order. Depends on sil_pkg and the block alone.
module sorted_interval_locator_tb;
	import sil_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam int     RANDOM_ITEMS  = 1950;
	localparam int     SETTLE_CYCLES = 20;
	localparam int     DRAIN_CYCLES  = 30;
	localparam int     MAX_REPORTS   = 10;
	localparam longint COORD_MIN     = -64'sd2147483648;
	localparam longint COORD_MAX     = 64'sd2147483647;

	typedef struct packed {
		logic                      mode;
		logic [NODE_W-1:0]         node_index;
		logic signed [COORD_W-1:0] coordinate;
	} sil_beat_t;

	typedef struct packed {
		logic              found;
		logic [NODE_W-1:0] cell_idx;
	} cell_hit_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LAST_W-1:0]    cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;  // node_index, coordinate, zero pad
	logic                 s_tuser = 1'b0; // mode
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // found, cell_index, zero pad

	logic signed [COORD_W-1:0] node_shadow [STORE_DEPTH];
	logic signed [COORD_W-1:0] planned_nodes [STORE_DEPTH];
	logic [NODE_W-1:0]         grid_origin = '0;
	logic [LAST_W-1:0]         grid_last = '1;
	sil_beat_t                 beat_backlog [$];
	cell_hit_t                 predicted_cells [$];
	sil_beat_t                 beat_on_bus;
	cell_hit_t                 expected_hit;
	int                        fail_count = 0;
	int                        item_total = 0;
	int                        beats_sent = 0;
	int                        results_seen = 0;
	int                        gap_left = 0;
	int                        stall_left = 0;

	sorted_interval_locator uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic int pick_pause();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic cell_hit_t locate_cell(input logic signed [COORD_W-1:0] coord);
		cell_hit_t hit;
		int top_cell, stop_idx, lo, hi, mid;
		hit = '0;
		if (grid_last[LAST_W-1]) return hit;
		top_cell = int'(grid_last);
		stop_idx = int'(grid_origin) + top_cell + 1;
		if (stop_idx >= STORE_DEPTH) return hit;
		if (coord < node_shadow[grid_origin] || coord >= node_shadow[stop_idx]) return hit;
		lo = 0;
		hi = top_cell;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			if (coord >= node_shadow[int'(grid_origin) + mid])
				lo = mid;
			else
				hi = mid - 1;
		end
		hit.found    = 1'b1;
		hit.cell_idx = lo[NODE_W-1:0];
		return hit;
	endfunction

	function automatic logic signed [COORD_W-1:0] pick_query(input int span_end);
		longint first_node, last_node, c, spread;
		int roll;
		logic signed [COORD_W-1:0] raw;
		first_node = planned_nodes[grid_origin];
		last_node  = planned_nodes[span_end];
		raw        = $urandom;
		spread     = $urandom;
		roll       = $urandom_range(0, 99);
		if (roll < 55 && last_node > first_node)
			c = first_node + spread % (last_node - first_node);
		else if (roll < 70)
			c = planned_nodes[int'(grid_origin) + $urandom_range(0, span_end - int'(grid_origin))];
		else if (roll < 80)
			c = first_node - $urandom_range(1, 4);
		else if (roll < 90)
			c = last_node + $urandom_range(0, 3);
		else
			c = raw;
		if (c < COORD_MIN) c = COORD_MIN;
		if (c > COORD_MAX) c = COORD_MAX;
		return c[COORD_W-1:0];
	endfunction

	task automatic report_failure(input string what);
		if (fail_count < MAX_REPORTS) $display("%0t: %s", $time, what);
		fail_count++;
	endtask

	task automatic queue_load(input int idx, input logic signed [COORD_W-1:0] value);
		sil_beat_t b;
		b.mode       = MODE_WRITE;
		b.node_index = idx[NODE_W-1:0];
		b.coordinate = value;
		planned_nodes[idx] = value;
		beat_backlog.push_back(b);
		item_total++;
	endtask

	task automatic queue_query(input logic signed [COORD_W-1:0] coord);
		sil_beat_t b;
		b.mode       = MODE_LOCATE;
		b.node_index = NODE_W'($urandom);
		b.coordinate = coord;
		beat_backlog.push_back(b);
		item_total++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LAST_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ORIGIN)
			grid_origin = data[NODE_W-1:0];
		else if (idx == REG_LAST_CELL)
			grid_last = data;
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (beat_backlog.size() != 0 || s_tvalid || predicted_cells.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic load_sorted_run(input int first, input int count);
		longint level, step_cap;
		logic signed [COORD_W-1:0] raw;
		int k;
		raw   = $urandom;
		level = raw;
		if ($urandom_range(0, 2) != 0) level = COORD_MIN + (level - COORD_MIN) / 4;
		step_cap = (COORD_MAX - level) / count;
		if ($urandom_range(0, 4) == 0 && step_cap > 3) step_cap = 3;
		for (k = 0; k < count; k++) begin
			queue_load(first + k, level[COORD_W-1:0]);
			level = level + $urandom_range(0, step_cap);
		end
	endtask

	task automatic run_phase(input logic [LAST_W-1:0] origin_word,
			input logic [LAST_W-1:0] last_word, input int queries);
		int k, span_end;
		logic [LAST_W-1:0] spare_word;
		logic signed [COORD_W-1:0] raw;
		bit searchable;
		wait_idle();
		write_reg(REG_ORIGIN, origin_word);
		write_reg(REG_LAST_CELL, last_word);
		if ($urandom_range(0, 4) == 0) begin
			spare_word = LAST_W'($urandom);
			write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, spare_word);
		end
		repeat (2) @(posedge clk);
		span_end   = int'(grid_origin) + int'(grid_last) + 1;
		searchable = !grid_last[LAST_W-1] && span_end < STORE_DEPTH;
		if (searchable) begin
			if ($urandom_range(0, 9) == 0) begin
				for (k = int'(grid_origin); k <= span_end; k++) queue_load(k, $urandom);
			end else begin
				load_sorted_run(int'(grid_origin), span_end - int'(grid_origin) + 1);
			end
		end
		for (k = 0; k < queries; k++) begin
			if ($urandom_range(0, 7) == 0) queue_load($urandom_range(0, STORE_DEPTH - 1), $urandom);
			if (searchable) begin
				queue_query(pick_query(span_end));
			end else begin
				raw = $urandom;
				queue_query(raw);
			end
		end
	endtask

	// source side: update the shadow store or predict on every accepted beat, then present the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (beat_on_bus.mode == MODE_WRITE)
					node_shadow[beat_on_bus.node_index] = beat_on_bus.coordinate;
				else
					predicted_cells.push_back(locate_cell(beat_on_bus.coordinate));
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (beat_backlog.size() > 0) begin
					beat_on_bus = beat_backlog.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= beat_on_bus.mode;
					s_tdata  <= {{(S_TDATA_W - NODE_W - COORD_W){1'b0}},
						beat_on_bus.coordinate, beat_on_bus.node_index};
					beats_sent++;
					gap_left = (beats_sent % 128 < 40) ? 0 : pick_pause();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result side: check each accepted beat against the oldest prediction, stall ready at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (predicted_cells.size() == 0) begin
					report_failure($sformatf("unexpected result beat: found %0b cell %0d",
						m_tdata[0], m_tdata[NODE_W:1]));
				end else begin
					expected_hit = predicted_cells.pop_front();
					if (m_tdata[0] !== expected_hit.found
					    || m_tdata[NODE_W:1] !== expected_hit.cell_idx)
						report_failure($sformatf(
							"result %0d: expected found %0b cell %0d, got found %0b cell %0d",
							results_seen, expected_hit.found, expected_hit.cell_idx,
							m_tdata[0], m_tdata[NODE_W:1]));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				stall_left = (results_seen % 64 < 16) ? 0 : pick_pause();
			end
		end
	end

	initial begin
		int roll, cells, first, random_goal;
		logic [LAST_W-1:0] origin_word, last_word;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty grid straight out of reset
		queue_query(32'sh8000_0000);
		queue_query(32'sh7FFF_FFFF);
		wait_idle();
		write_reg(REG_ORIGIN, 11'h7FF);
		write_reg(REG_LAST_CELL, 11'h400);
		queue_query(32'sd12345);
		wait_idle();
		// grid ends one past the store
		write_reg(REG_LAST_CELL, 11'd0);
		queue_load(STORE_DEPTH - 1, 32'sh7FFF_FFFF);
		queue_query(32'sd0);
		wait_idle();
		// bit above the origin width is dropped, spare index does nothing
		write_reg(REG_ORIGIN, 11'h400);
		write_reg(REG_LAST_CELL, 11'd2);
		write_reg(REG_SPARE_B, 11'h005);
		queue_load(0, 32'sh8000_0000);
		queue_load(1, -32'sd65536);
		queue_load(2, 32'sd0);
		queue_load(3, 32'sh7FFF_FFFF);
		queue_query(32'sh8000_0000);
		queue_query(-32'sd1);
		queue_query(32'sd0);
		queue_query(32'sh7FFF_FFFE);
		queue_query(32'sh7FFF_FFFF);
		queue_load(0, -32'sd100);
		queue_query(-32'sd101);
		queue_query(-32'sd100);
		wait_idle();
		// nodes out of order near the store end
		write_reg(REG_ORIGIN, 11'd1020);
		write_reg(REG_LAST_CELL, 11'd2);
		queue_load(1020, 32'sd5);
		queue_load(1021, 32'sd100);
		queue_load(1022, -32'sd50);
		queue_query(32'sd50);
		queue_query(32'sd200);

		random_goal = item_total + RANDOM_ITEMS;
		// deepest search: the whole store as one grid
		run_phase(11'd0, 11'd1022, 150);
		while (item_total < random_goal) begin
			roll = $urandom_range(0, 9);
			if (roll < 8) begin
				roll = $urandom_range(0, 9);
				cells = (roll < 6) ? $urandom_range(0, 7) :
					(roll < 9) ? $urandom_range(8, 63) : $urandom_range(64, 300);
				first = $urandom_range(0, STORE_DEPTH - 2 - cells);
				origin_word = LAST_W'(first);
				origin_word[LAST_W-1] = 1'($urandom_range(0, 1));
				last_word = LAST_W'(cells);
				run_phase(origin_word, last_word, $urandom_range(5, 40));
			end else if (roll == 8) begin
				origin_word = LAST_W'($urandom);
				last_word = LAST_W'($urandom);
				last_word[LAST_W-1] = 1'b1;
				if ($urandom_range(0, 1)) last_word = '1;
				run_phase(origin_word, last_word, $urandom_range(5, 20));
			end else begin
				first = $urandom_range(0, STORE_DEPTH - 1);
				cells = $urandom_range(STORE_DEPTH - 1 - first, STORE_DEPTH - 1);
				origin_word = LAST_W'(first);
				origin_word[LAST_W-1] = 1'($urandom_range(0, 1));
				last_word = LAST_W'(cells);
				run_phase(origin_word, last_word, $urandom_range(5, 20));
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (predicted_cells.size() != 0)
			report_failure($sformatf("%0d results never arrived", predicted_cells.size()));
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/sil_pkg.sv
hdl/sil_front.sv
hdl/sil_queue.sv
hdl/sil_back.sv
hdl/sorted_interval_locator.sv
hdl/sil_checker.sv
tb/sorted_interval_locator_tb.sv
